[src/ihpq_pkg.sv]
// Package for the interval heap priority queue: field widths, command and status codes.
// No dependencies.
`default_nettype none
package ihpq_pkg;
    localparam int Capacity  = 128;
    localparam int Nodes     = (Capacity + 1) / 2;
    localparam int NodeBits  = $clog2(Nodes);
    localparam int CountBits = $clog2(Capacity + 1);
    localparam int KeyBits   = 31;
    localparam int TagBits   = 16;
    localparam int EntryBits = KeyBits + TagBits;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CmdInsert = 2'd0;
    localparam t_cmd CmdPopMin = 2'd1;
    localparam t_cmd CmdPopMax = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status StOk    = 2'd0;
    localparam t_status StFull  = 2'd1;
    localparam t_status StEmpty = 2'd2;

    typedef struct packed {
        logic [KeyBits-1:0] key;
        logic [TagBits-1:0] tag;
    } t_entry;

    typedef struct packed {
        t_cmd               cmd;
        logic [KeyBits-1:0] key;
        logic [TagBits-1:0] tag;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [KeyBits-1:0] out_key;
        logic [TagBits-1:0] out_tag;
        logic [7:0]         occupancy;
    } t_rsp;
endpackage
`default_nettype wire

[src/ihpq_if.sv]
// Valid/ready channel interfaces for requests and responses, each carrying one payload struct.
// Depends on ihpq_pkg.
`default_nettype none
interface ihpq_req_if;
    logic             valid;
    logic             ready;
    ihpq_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ihpq_rsp_if;
    logic             valid;
    logic             ready;
    ihpq_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/ihpq_ram.sv]
// Generic single-port-write, two-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module ihpq_ram #(
    parameter int Width = 8,
    parameter int Depth = 4,
    parameter int AddrBits = $clog2(Depth)
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AddrBits-1:0] i_waddr,
    input  wire logic [Width-1:0]    i_wdata,
    input  wire logic [AddrBits-1:0] i_raddr_a,
    input  wire logic [AddrBits-1:0] i_raddr_b,
    output logic      [Width-1:0]    o_rdata_a,
    output logic      [Width-1:0]    o_rdata_b
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

[src/interval_heap_priority_queue_core.sv]
// Top level of the interval heap priority queue: sequencer plus low and high entry memories.
// Depends on ihpq_pkg, ihpq_if and ihpq_ram.
`default_nettype none
// One request at a time is served. A step of the heap walk reads the nodes it needs from
// the low and high memories and then writes back through states S_WR0 to S_WR3. An insert
// step reads the node and its parent; an insert takes one step plus one per level risen.
// A pop fetches the root and the last entry, writes the moved entry into the root, and
// then takes one step per level sunk (node, children and write-back). A full, empty or
// unused request goes straight to S_DONE. The result waits in its own register, and the
// next request is accepted from the cycle after the result is posted.
module interval_heap_priority_queue_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ihpq_req_if.sink    i_req,
    ihpq_rsp_if.source  o_rsp
);
    localparam int NB = ihpq_pkg::NodeBits;
    localparam int CB = ihpq_pkg::CountBits;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_EVAL, S_WR0, S_WR1, S_WR2, S_WR3, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        M_INS_EVEN, M_INS_ODD, M_RISE_LO, M_RISE_HI, M_POP_FETCH, M_SINK_LO, M_SINK_HI
    } t_mode;

    t_state             r_state;
    t_mode              r_mode;
    ihpq_pkg::t_req     r_req;
    logic [CB-1:0]      r_cnt, r_n;
    logic [NB-1:0]      r_i;
    logic               r_rsp_valid;
    ihpq_pkg::t_rsp     r_rsp;
    ihpq_pkg::t_rsp     r_out;

    // memory ports
    logic               lo_we, hi_we;
    logic [NB-1:0]      lo_wa, hi_wa, lo_ra, lo_rb, hi_ra, hi_rb;
    ihpq_pkg::t_entry   lo_wd, hi_wd, lo_a, lo_b, hi_a, hi_b;
    logic [NB-1:0]      r_ra, r_rb;

    // captured node data: a = node i, b = parent or left child, c = right child
    ihpq_pkg::t_entry   r_la, r_ha, r_lb, r_hb, r_lc, r_hc;

    // pending writes: up to four
    logic [3:0]         r_wv;
    logic [3:0]         r_whi;
    logic [NB-1:0]      r_wad [4];
    ihpq_pkg::t_entry   r_wdt [4];
    logic               r_stop;
    logic [NB-1:0]      r_next;

    ihpq_ram #(.Width(ihpq_pkg::EntryBits), .Depth(ihpq_pkg::Nodes)) u_lo (
        .i_clk, .i_we(lo_we), .i_waddr(lo_wa), .i_wdata(lo_wd),
        .i_raddr_a(lo_ra), .i_raddr_b(lo_rb), .o_rdata_a(lo_a), .o_rdata_b(lo_b)
    );
    ihpq_ram #(.Width(ihpq_pkg::EntryBits), .Depth(ihpq_pkg::Nodes)) u_hi (
        .i_clk, .i_we(hi_we), .i_waddr(hi_wa), .i_wdata(hi_wd),
        .i_raddr_a(hi_ra), .i_raddr_b(hi_rb), .o_rdata_a(hi_a), .o_rdata_b(hi_b)
    );

    // read addresses: port a and b, third node via a second read pass
    logic r_phase;
    always_comb begin
        lo_ra = r_ra;
        hi_ra = r_ra;
        lo_rb = r_rb;
        hi_rb = r_rb;
    end

    // write port steering
    logic [1:0] wsel;
    always_comb begin
        wsel = 2'd0;
        case (r_state)
            S_WR0:   wsel = 2'd0;
            S_WR1:   wsel = 2'd1;
            S_WR2:   wsel = 2'd2;
            S_WR3:   wsel = 2'd3;
            default: wsel = 2'd0;
        endcase
        lo_we = 1'b0;
        hi_we = 1'b0;
        if (r_state == S_WR0 || r_state == S_WR1 || r_state == S_WR2
                || r_state == S_WR3) begin
            lo_we = r_wv[wsel] && !r_whi[wsel];
            hi_we = r_wv[wsel] && r_whi[wsel];
        end
        lo_wa = r_wad[wsel];
        hi_wa = r_wad[wsel];
        lo_wd = r_wdt[wsel];
        hi_wd = r_wdt[wsel];
    end

    function automatic logic [NB-1:0] parent(input logic [NB-1:0] i);
        parent = NB'((i - NB'(1)) >> 1);
    endfunction

    function automatic logic nfull(input logic [NB-1:0] i, input logic [CB-1:0] n);
        nfull = ({1'b0, i, 1'b1} < (CB+2)'(n));
    endfunction

    // evaluation of one step
    logic [3:0]         e_wv, e_whi;
    logic [NB-1:0]      e_wad [4];
    ihpq_pkg::t_entry   e_wdt [4];
    logic               e_stop;
    t_mode              e_mode;
    logic [NB-1:0]      e_next;
    logic [CB:0]        nodes;
    logic [NB+1:0]      lch, rch;
    logic               has_l, has_r, takel, fa, fl, fr;
    ihpq_pkg::t_entry   lo_i, hi_i, ctop, ltop, rtop, lnew;
    ihpq_pkg::t_entry   ins;
    logic [NB-1:0]      cidx;
    logic               chi;

    always_comb begin
        e_wv = '0;
        e_whi = '0;
        for (int k = 0; k < 4; k++) begin
            e_wad[k] = r_i;
            e_wdt[k] = r_la;
        end
        e_stop = 1'b1;
        e_mode = r_mode;
        e_next = r_i;
        nodes = (CB+1)'((r_n + CB'(1)) >> 1);
        lch = {1'b0, r_i, 1'b1};
        rch = (NB+2)'({1'b0, r_i, 1'b0} + (NB+2)'(2));
        has_l = (CB+1)'(lch) < nodes;
        has_r = (CB+1)'(rch) < nodes;
        fa = nfull(r_i, r_n);
        fl = has_l && nfull(NB'(lch), r_n);
        fr = has_r && nfull(NB'(rch), r_n);
        ins.key = r_req.key;
        ins.tag = r_req.tag;
        lo_i = r_la;
        hi_i = r_ha;
        ltop = fl ? r_hb : r_lb;
        rtop = fr ? r_hc : r_lc;
        takel = 1'b0;
        ctop = ltop;
        cidx = NB'(lch);
        chi = fl;
        lnew = r_la;
        case (r_mode)
            M_INS_EVEN: begin
                // a = node i (unused), b = parent
                e_wv[0] = 1'b1; e_whi[0] = 1'b0; e_wad[0] = r_i; e_wdt[0] = ins;
                if (r_i != '0) begin
                    if (r_lb.key > ins.key) begin
                        e_wdt[0] = r_lb;
                        e_wv[1] = 1'b1; e_wad[1] = parent(r_i); e_wdt[1] = ins;
                        e_stop = (parent(r_i) == '0);
                        e_mode = M_RISE_LO; e_next = parent(r_i);
                    end else if (r_hb.key < ins.key) begin
                        e_wdt[0] = r_hb;
                        e_wv[1] = 1'b1; e_whi[1] = 1'b1; e_wad[1] = parent(r_i);
                        e_wdt[1] = ins;
                        e_stop = (parent(r_i) == '0);
                        e_mode = M_RISE_HI; e_next = parent(r_i);
                    end
                end
            end
            M_INS_ODD: begin
                // a = node i, b = parent
                if (r_la.key < ins.key) begin
                    e_wv[0] = 1'b1; e_whi[0] = 1'b1; e_wdt[0] = ins;
                    if (r_i != '0 && r_hb.key < ins.key) begin
                        e_wdt[0] = r_hb;
                        e_wv[1] = 1'b1; e_whi[1] = 1'b1; e_wad[1] = parent(r_i);
                        e_wdt[1] = ins;
                        e_stop = (parent(r_i) == '0);
                        e_mode = M_RISE_HI; e_next = parent(r_i);
                    end
                end else begin
                    e_wv[0] = 1'b1; e_whi[0] = 1'b1; e_wdt[0] = r_la;
                    e_wv[1] = 1'b1; e_wdt[1] = ins;
                    if (r_i != '0 && r_lb.key > ins.key) begin
                        e_wdt[1] = r_lb;
                        e_wv[2] = 1'b1; e_wad[2] = parent(r_i); e_wdt[2] = ins;
                        e_stop = (parent(r_i) == '0);
                        e_mode = M_RISE_LO; e_next = parent(r_i);
                    end
                end
            end
            M_RISE_LO: begin
                // a = node i (holds risen entry), b = parent
                if (r_lb.key > r_la.key) begin
                    e_wv[0] = 1'b1; e_wdt[0] = r_lb;
                    e_wv[1] = 1'b1; e_wad[1] = parent(r_i); e_wdt[1] = r_la;
                    e_stop = (parent(r_i) == '0);
                    e_next = parent(r_i);
                end
            end
            M_RISE_HI: begin
                if (r_hb.key < r_ha.key) begin
                    e_wv[0] = 1'b1; e_whi[0] = 1'b1; e_wdt[0] = r_hb;
                    e_wv[1] = 1'b1; e_whi[1] = 1'b1; e_wad[1] = parent(r_i);
                    e_wdt[1] = r_ha;
                    e_stop = (parent(r_i) == '0);
                    e_next = parent(r_i);
                end
            end
            M_SINK_LO: begin
                if (fa && lo_i.key > hi_i.key) begin
                    lo_i = r_ha;
                    hi_i = r_la;
                    e_wv[0] = 1'b1; e_wdt[0] = lo_i;
                    e_wv[1] = 1'b1; e_whi[1] = 1'b1; e_wdt[1] = hi_i;
                end
                if (has_l) begin
                    takel = !has_r || (r_lb.key < r_lc.key);
                    ctop = takel ? r_lb : r_lc;
                    cidx = takel ? NB'(lch) : NB'(rch);
                    if (lo_i.key > ctop.key) begin
                        e_wv[0] = 1'b1; e_wdt[0] = ctop;
                        e_wv[2] = 1'b1; e_wad[2] = cidx; e_wdt[2] = lo_i;
                        e_stop = 1'b0;
                        e_next = cidx;
                    end
                end
            end
            M_SINK_HI: begin
                if (fa) begin
                    if (lo_i.key > hi_i.key) begin
                        lo_i = r_ha;
                        hi_i = r_la;
                        e_wv[0] = 1'b1; e_wdt[0] = lo_i;
                        e_wv[1] = 1'b1; e_whi[1] = 1'b1; e_wdt[1] = hi_i;
                    end
                    if (has_l) begin
                        takel = !has_r || (ltop.key > rtop.key);
                        ctop = takel ? ltop : rtop;
                        cidx = takel ? NB'(lch) : NB'(rch);
                        chi = takel ? fl : fr;
                        if (hi_i.key < ctop.key) begin
                            e_wv[1] = 1'b1; e_whi[1] = 1'b1; e_wdt[1] = ctop;
                            e_wv[2] = 1'b1; e_whi[2] = chi; e_wad[2] = cidx;
                            e_wdt[2] = hi_i;
                            e_stop = 1'b0;
                            e_next = cidx;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        // keep unused slot write after a node swap ordered
        e_wad[3] = r_i;
        e_wdt[3] = lnew;
    end

    logic [CB-1:0] m_cnt;
    logic [NB-1:0] last_node;
    assign m_cnt = r_cnt - CB'(1);
    assign last_node = NB'(m_cnt >> 1);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
            r_wv        <= '0;
        end else begin
            if (r_rsp_valid && o_rsp.ready && r_state != S_DONE) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.data;
                        r_wv  <= '0;
                        r_rsp.out_key   <= '0;
                        r_rsp.out_tag   <= '0;
                        case (i_req.data.cmd)
                            ihpq_pkg::CmdInsert: begin
                                if (r_cnt >= CB'(ihpq_pkg::Capacity)) begin
                                    r_rsp.status <= ihpq_pkg::StFull;
                                    r_rsp.occupancy <= 8'(r_cnt);
                                    r_state <= S_DONE;
                                end else begin
                                    r_rsp.status <= ihpq_pkg::StOk;
                                    r_rsp.occupancy <= 8'(r_cnt + CB'(1));
                                    r_i    <= NB'(r_cnt >> 1);
                                    r_ra   <= NB'(r_cnt >> 1);
                                    r_rb   <= parent(NB'(r_cnt >> 1));
                                    r_mode <= r_cnt[0] ? M_INS_ODD : M_INS_EVEN;
                                    r_n    <= r_cnt + CB'(1);
                                    r_cnt  <= r_cnt + CB'(1);
                                    r_phase <= 1'b0;
                                    r_state <= S_RD;
                                end
                            end
                            ihpq_pkg::CmdPopMin, ihpq_pkg::CmdPopMax: begin
                                if (r_cnt == '0) begin
                                    r_rsp.status <= ihpq_pkg::StEmpty;
                                    r_rsp.occupancy <= 8'(r_cnt);
                                    r_state <= S_DONE;
                                end else begin
                                    r_rsp.status <= ihpq_pkg::StOk;
                                    r_rsp.occupancy <= 8'(m_cnt);
                                    r_ra   <= '0;
                                    r_rb   <= last_node;
                                    r_i    <= '0;
                                    r_n    <= m_cnt;
                                    r_cnt  <= m_cnt;
                                    r_mode <= M_POP_FETCH;
                                    r_phase <= 1'b0;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_rsp.status <= ihpq_pkg::StOk;
                                r_rsp.occupancy <= 8'(r_cnt);
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_mode == M_POP_FETCH) begin
                        ihpq_pkg::t_entry mv;
                        ihpq_pkg::t_entry rs;
                        mv = r_n[0] ? hi_b : lo_b;
                        if (r_req.cmd == ihpq_pkg::CmdPopMin) begin
                            rs = lo_a;
                        end else begin
                            rs = (r_n != '0) ? hi_a : lo_a;
                        end
                        r_rsp.out_key <= rs.key;
                        r_rsp.out_tag <= rs.tag;
                        if (r_req.cmd == ihpq_pkg::CmdPopMin && r_n != '0) begin
                            r_wv <= 4'b0001; r_whi[0] <= 1'b0; r_wad[0] <= '0;
                            r_wdt[0] <= mv;
                            r_mode <= M_SINK_LO;
                            r_stop <= 1'b0; r_next <= '0;
                            r_state <= S_WR0;
                        end else if (r_req.cmd == ihpq_pkg::CmdPopMax && r_n >= CB'(2)) begin
                            r_wv <= 4'b0001; r_whi[0] <= 1'b1; r_wad[0] <= '0;
                            r_wdt[0] <= mv;
                            r_mode <= M_SINK_HI;
                            r_stop <= 1'b0; r_next <= '0;
                            r_state <= S_WR0;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (!r_phase) begin
                        r_la <= lo_a; r_ha <= hi_a;
                        r_lb <= lo_b; r_hb <= hi_b;
                        if (r_mode == M_SINK_LO || r_mode == M_SINK_HI) begin
                            r_ra <= NB'({r_i, 1'b0} + (NB+1)'(2));
                            r_phase <= 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end else begin
                        r_lc <= lo_a; r_hc <= hi_a;
                        r_phase <= 1'b0;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_wv <= e_wv;
                    r_whi <= e_whi;
                    for (int k = 0; k < 4; k++) begin
                        r_wad[k] <= e_wad[k];
                        r_wdt[k] <= e_wdt[k];
                    end
                    r_stop <= e_stop;
                    r_next <= e_next;
                    r_mode <= e_mode;
                    r_state <= S_WR0;
                end
                S_WR0: r_state <= S_WR1;
                S_WR1: r_state <= S_WR2;
                S_WR2: r_state <= S_WR3;
                S_WR3: begin
                    if (r_stop) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_next;
                        r_ra <= r_next;
                        if (r_mode == M_RISE_LO || r_mode == M_RISE_HI) begin
                            r_rb <= parent(r_next);
                        end else begin
                            r_rb <= NB'({r_next, 1'b1});
                        end
                        r_phase <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_rsp_valid <= 1'b1;
                        r_out <= r_rsp;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CB'(ihpq_pkg::Capacity)) else $error("count above capacity");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(lo_we && hi_we)) else $error("two memory writes in one cycle");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> o_rsp.valid) else $error("response dropped");
endmodule
`default_nettype wire
